// ===== hdl/miss_stride_prefetcher_defines.svh =====
// Assertion macros for the prefetcher.
`ifndef MISS_STRIDE_PREFETCHER_DEFINES_SVH
`define MISS_STRIDE_PREFETCHER_DEFINES_SVH
`ifndef SYNTHESIS
`define MSP_ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");
`define MSP_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define MSP_ASSERT_IMPL(label, clk, rst, a, b)
`define MSP_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== hdl/msp_pkg.sv =====
package msp_pkg;
  localparam int TABLE_ENTRIES  = 1024;
  localparam int PREFETCH_COUNT = 2;
  localparam int IDX_W          = $clog2(TABLE_ENTRIES);
  localparam int K_W            = $clog2(PREFETCH_COUNT + 1);
  localparam int LINE_SHIFT     = 6;
  localparam int PAGE_SHIFT     = 12;
  localparam int LINE_W         = 32 - LINE_SHIFT + 2;
  localparam int PAGE_W         = LINE_W - (PAGE_SHIFT - LINE_SHIFT);
  localparam logic [6:0] RESET_THRESHOLD = 7'd8;
  localparam logic [7:0] CONF_TRUSTED    = 8'd2;
  localparam logic [7:0] CONF_DEMOTED    = 8'd1;

  typedef struct packed {
    logic [31:0] access_address;
    logic [31:0] time_stamp;
    logic [6:0]  queue_occupancy;
  } req_t;

  typedef struct packed {
    logic [31:0] prefetch_address;
    logic        fill_outer;
    logic        last_request;
  } rsp_t;

  typedef struct packed {
    logic        is_new;
    logic [31:0] address;
    logic [31:0] stamp;
    logic [15:0] stride;
    logic [7:0]  conf;
  } entry_t;
endpackage

// ===== hdl/miss_stride_prefetcher.sv =====
// Channel   | Direction | Handshake              | Payload
// request   | in        | in_valid / in_ready    | in_req  (msp_pkg::req_t)
// result    | out       | out_valid / out_ready  | out_rsp (msp_pkg::rsp_t)
// threshold | in        | cfg_we (no wait)       | cfg_data
//
// A hit takes two full sweeps of the table; a miss takes three sweeps and a
// calculation step, then emits its results. The table rotates one entry per
// cycle past a single head compare unit during each sweep.
// Synchronous reset clears every entry and loads the threshold with 8 at once.
// A stalled result holds in the output register; no new request is taken until
// all results of the current one are delivered.
`include "miss_stride_prefetcher_defines.svh"
module miss_stride_prefetcher (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  msp_pkg::req_t in_req,
  output logic          out_valid,
  input  logic          out_ready,
  output msp_pkg::rsp_t out_rsp,
  input  logic          cfg_we,
  input  logic [6:0]    cfg_data
);
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN1 = 3'd1; // match, oldest, newest
  localparam logic [2:0] ST_SCAN2 = 3'd2; // second-newest, capture fields, hit refresh
  localparam logic [2:0] ST_CALC  = 3'd3;
  localparam logic [2:0] ST_SCAN3 = 3'd4; // write replaced and newest entries
  localparam logic [2:0] ST_EMIT  = 3'd5;

  localparam logic [msp_pkg::IDX_W-1:0] LAST_IDX = msp_pkg::IDX_W'(msp_pkg::TABLE_ENTRIES - 1);

  logic [2:0] state;
  logic [msp_pkg::IDX_W-1:0] idx;
  logic [6:0] thr;
  msp_pkg::req_t req;
  logic outer;

  logic hit_found;
  logic [msp_pkg::IDX_W-1:0] hit_idx, o_idx, n_idx, sec_idx;
  logic [31:0] min_stamp, max_stamp, best;
  logic sec_found;
  logic [31:0] a_n;
  logic [15:0] s_n, s_sec;
  logic [7:0]  c_n, c_o;

  logic [15:0] s_new, stride_use;
  logic [7:0]  co, cn;

  logic signed [msp_pkg::LINE_W-1:0] line;
  logic [msp_pkg::K_W-1:0] k;

  msp_pkg::entry_t head, wrap;
  logic shift;
  logic last_pass;

  assign shift     = (state == ST_SCAN1) || (state == ST_SCAN2) || (state == ST_SCAN3);
  assign last_pass = (idx == LAST_IDX);

  msp_chain u_chain (.clk(clk), .rst(rst), .shift(shift), .wrap(wrap), .head(head));

  // Modify the head entry on its way back into the tail.
  always_comb begin
    wrap = head;
    if (state == ST_SCAN2 && hit_found && idx == hit_idx) begin
      wrap.is_new = 1'b0;
      wrap.stamp  = req.time_stamp;
    end else if (state == ST_SCAN3) begin
      if (idx == o_idx) begin
        wrap.is_new  = 1'b1;
        wrap.address = req.access_address;
        wrap.stamp   = req.time_stamp;
        wrap.stride  = s_new;
        wrap.conf    = co;
      end else if (idx == n_idx) begin
        wrap.conf = cn;
      end
    end
  end

  // Stride and confidence update, with the replaced entry possibly aliasing
  // the newest or second-newest one.
  logic [31:0] a_n_eff;
  logic [15:0] s_calc, sn_eff, ssec_eff;
  logic [7:0]  cn_eff, co_calc, cn_calc;
  logic use_learned;
  always_comb begin
    a_n_eff  = (o_idx == n_idx) ? req.access_address : a_n;
    s_calc   = req.access_address[15:0] - a_n_eff[15:0];
    sn_eff   = (o_idx == n_idx) ? s_calc : s_n;
    ssec_eff = (o_idx == sec_idx) ? s_calc : s_sec;
    cn_eff   = (o_idx == n_idx) ? c_o : c_n;
    co_calc  = c_o;
    cn_calc  = c_n;
    if (s_calc == sn_eff) begin
      co_calc = cn_eff + 8'd1;
    end else if (s_calc == ssec_eff) begin
      cn_calc = msp_pkg::CONF_TRUSTED;
    end
    if (co_calc == msp_pkg::CONF_TRUSTED) begin
      co_calc = msp_pkg::CONF_DEMOTED;
    end
    if (o_idx == n_idx) begin
      cn_calc = co_calc;
    end
    use_learned = (cn_calc == msp_pkg::CONF_TRUSTED);
    if (use_learned) begin
      cn_calc = '0;
    end
  end

  // Next prefetch line and whether it stays in the page.
  logic signed [msp_pkg::LINE_W-1:0] line_next;
  logic next_ok, last_now;
  always_comb begin
    line_next = line + msp_pkg::LINE_W'(signed'(stride_use));
    next_ok   = (line_next[msp_pkg::LINE_W-1:msp_pkg::PAGE_SHIFT-msp_pkg::LINE_SHIFT] ==
                 msp_pkg::PAGE_W'(req.access_address[31:msp_pkg::PAGE_SHIFT]));
    last_now  = (k == msp_pkg::K_W'(msp_pkg::PREFETCH_COUNT - 1)) || !next_ok;
  end

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_EMIT);
  assign out_rsp.prefetch_address = {line[31-msp_pkg::LINE_SHIFT:0],
                                     msp_pkg::LINE_SHIFT'(0)};
  assign out_rsp.fill_outer   = outer;
  assign out_rsp.last_request = last_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= msp_pkg::RESET_THRESHOLD;
    end else if (cfg_we) begin
      thr <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req       <= in_req;
            outer     <= (in_req.queue_occupancy >= thr);
            idx       <= '0;
            hit_found <= 1'b0;
            state     <= ST_SCAN1;
          end
        end
        ST_SCAN1: begin
          if (!hit_found && head.address == req.access_address) begin
            hit_found <= 1'b1;
            hit_idx   <= idx;
          end
          if (idx == '0 || head.stamp < min_stamp) begin
            min_stamp <= head.stamp;
            o_idx     <= idx;
          end
          if (idx == '0 || head.stamp > max_stamp) begin
            max_stamp <= head.stamp;
            n_idx     <= idx;
          end
          idx <= last_pass ? '0 : idx + 1'b1;
          if (last_pass) begin
            sec_found <= 1'b0;
            state     <= ST_SCAN2;
          end
        end
        ST_SCAN2: begin
          if (idx == n_idx) begin
            a_n <= head.address;
            s_n <= head.stride;
            c_n <= head.conf;
          end
          if (idx == o_idx) begin
            c_o <= head.conf;
          end
          // Default to entry 0 when no stamp lies below the newest.
          if (head.stamp < max_stamp && (!sec_found || head.stamp > best)) begin
            sec_found <= 1'b1;
            best      <= head.stamp;
            sec_idx   <= idx;
            s_sec     <= head.stride;
          end else if (idx == '0) begin
            sec_idx <= '0;
            s_sec   <= head.stride;
          end
          idx <= last_pass ? '0 : idx + 1'b1;
          if (last_pass) begin
            state <= hit_found ? ST_IDLE : ST_CALC;
          end
        end
        ST_CALC: begin
          s_new      <= s_calc;
          co         <= co_calc;
          cn         <= cn_calc;
          stride_use <= use_learned ? sn_eff : 16'd1;
          state      <= ST_SCAN3;
        end
        ST_SCAN3: begin
          idx <= last_pass ? '0 : idx + 1'b1;
          if (last_pass) begin
            line  <= msp_pkg::LINE_W'(req.access_address[31:msp_pkg::LINE_SHIFT]);
            k     <= '0;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_ready) begin
            if (last_now) begin
              state <= ST_IDLE;
            end else begin
              line <= line_next;
              k    <= k + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Never take a request while results are pending.
  `MSP_ASSERT_IMPL(a_no_overlap, clk, rst, out_valid, !in_ready)
  // A delivered result that is not the last one is followed by another.
  `MSP_ASSERT_NEXT(a_more_follow, clk, rst,
                   out_valid && out_ready && !out_rsp.last_request, out_valid)
  // An accepted request starts a table sweep.
  `MSP_ASSERT_NEXT(a_sweep_start, clk, rst, in_valid && in_ready, !in_ready && !out_valid)
endmodule

// ===== hdl/msp_cell.sv =====
// One table entry; loads its neighbor's entry on shift.
module msp_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift,
  input  msp_pkg::entry_t d,
  output msp_pkg::entry_t q
);
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end
endmodule

// ===== hdl/msp_chain.sv =====
// Circular row of cells; cell 0 is the head, the wrap input feeds the tail.
module msp_chain (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift,
  input  msp_pkg::entry_t wrap,
  output msp_pkg::entry_t head
);
  msp_pkg::entry_t q [msp_pkg::TABLE_ENTRIES];

  for (genvar i = 0; i < msp_pkg::TABLE_ENTRIES; i++) begin : g_cell
    msp_pkg::entry_t d;
    if (i == msp_pkg::TABLE_ENTRIES - 1) begin : g_tail
      assign d = wrap;
    end else begin : g_mid
      assign d = q[i + 1];
    end
    msp_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d(d), .q(q[i]));
  end

  assign head = q[0];
endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  localparam int BUSY_WAIT   = 3300;   // longest miss plus results, with margin
  localparam int STALL_LIMIT = 20000;  // cycles with no handshake before giving up
  localparam int LONG_HOLD   = 4000;   // outlasts a full miss sweep so results back up

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  msp_pkg::req_t        in_req = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  msp_pkg::rsp_t        out_rsp;
  logic                 cfg_we = 1'b0;
  logic [6:0]           cfg_data = '0;

  always #5 clk = ~clk;

  miss_stride_prefetcher DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
    .out_valid(out_valid), .out_ready(out_ready), .out_rsp(out_rsp),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // Shadow of the prefetch table and the threshold register.
  logic        sh_new    [msp_pkg::TABLE_ENTRIES];
  logic [31:0] sh_addr   [msp_pkg::TABLE_ENTRIES];
  logic [31:0] sh_stamp  [msp_pkg::TABLE_ENTRIES];
  logic [15:0] sh_stride [msp_pkg::TABLE_ENTRIES];
  logic [7:0]  sh_conf   [msp_pkg::TABLE_ENTRIES];
  logic [6:0]  sh_thresh;

  msp_pkg::rsp_t pending_prefetches[$];
  int   errors = 0;
  bit   calm = 1'b0;
  bit   hold_req = 1'b0;

  // Table walk for one request: returns the prefetches it produces.
  task automatic predict_prefetches(input msp_pkg::req_t r, output msp_pkg::rsp_t pf_list[$]);
    int oldest, newest, second;
    bit found, outer;
    logic [31:0] best;
    int signed use_stride;
    longint line, pf;
    pf_list = {};
    for (int i = 0; i < msp_pkg::TABLE_ENTRIES; i++) begin
      if (sh_addr[i] == r.access_address) begin
        sh_new[i]   = 1'b0;
        sh_stamp[i] = r.time_stamp;
        return;
      end
    end
    oldest = 0; newest = 0; second = 0; found = 1'b0; best = '0;
    for (int i = 1; i < msp_pkg::TABLE_ENTRIES; i++)
      if (sh_stamp[i] < sh_stamp[oldest]) oldest = i;
    for (int i = 1; i < msp_pkg::TABLE_ENTRIES; i++)
      if (sh_stamp[i] > sh_stamp[newest]) newest = i;
    for (int i = 0; i < msp_pkg::TABLE_ENTRIES; i++) begin
      if (sh_stamp[i] < sh_stamp[newest] && (!found || sh_stamp[i] > best)) begin
        found = 1'b1; best = sh_stamp[i]; second = i;
      end
    end
    sh_new[oldest]    = 1'b1;
    sh_addr[oldest]   = r.access_address;
    sh_stamp[oldest]  = r.time_stamp;
    sh_stride[oldest] = 16'(r.access_address - sh_addr[newest]);
    if (sh_stride[oldest] == sh_stride[newest])
      sh_conf[oldest] = sh_conf[newest] + 8'd1;
    else if (sh_stride[oldest] == sh_stride[second])
      sh_conf[newest] = msp_pkg::CONF_TRUSTED;
    if (sh_conf[oldest] == msp_pkg::CONF_TRUSTED) sh_conf[oldest] = msp_pkg::CONF_DEMOTED;
    if (sh_conf[newest] == msp_pkg::CONF_TRUSTED) begin
      use_stride = int'($signed(sh_stride[newest]));
      sh_conf[newest] = '0;
    end else begin
      use_stride = 1;
    end
    outer = (r.queue_occupancy >= sh_thresh);
    for (int k = 0; k < msp_pkg::PREFETCH_COUNT; k++) begin
      line = longint'(r.access_address >> msp_pkg::LINE_SHIFT)
             + longint'(k) * longint'(use_stride);
      if (line < 0) break;
      pf = line << msp_pkg::LINE_SHIFT;
      if ((pf >> msp_pkg::PAGE_SHIFT) != longint'(r.access_address >> msp_pkg::PAGE_SHIFT))
        break;
      pf_list.push_back('{prefetch_address: pf[31:0], fill_outer: outer, last_request: 1'b0});
    end
    if (pf_list.size() > 0) pf_list[pf_list.size()-1].last_request = 1'b1;
  endtask

  // Offer one request with random gaps, hold it until taken, then return the
  // predicted prefetches.
  task automatic send_request(input msp_pkg::req_t r, output msp_pkg::rsp_t pf_list[$]);
    while (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
    predict_prefetches(r, pf_list);
  endtask

  task automatic issue(input msp_pkg::req_t r);
    msp_pkg::rsp_t pf_list[$];
    send_request(r, pf_list);
    foreach (pf_list[i]) pending_prefetches.push_back(pf_list[i]);
  endtask

  // Drain results and let a trailing hit finish before touching the register.
  task automatic write_threshold(input logic [6:0] v);
    in_valid <= 1'b0;
    while (pending_prefetches.size() != 0) @(posedge clk);
    repeat (BUSY_WAIT) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sh_thresh = v;
  endtask

  // Random traffic: mostly strided runs from a random base, some hits and noise.
  logic [31:0] clock_stamp = 32'd100;
  task automatic random_phase(input int n_items);
    int done;
    logic [31:0] base;
    int signed step;
    int run_len;
    msp_pkg::req_t r;
    done = 0;
    while (done < n_items) begin
      base = $urandom();
      case ($urandom_range(5))
        0: step = 64;
        1: step = -64;
        2: step = 128;
        3: step = 64 * $urandom_range(1, 8);
        4: step = -64 * $urandom_range(1, 4);
        default: step = int'($urandom_range(1, 300));
      endcase
      run_len = $urandom_range(3, 8);
      for (int j = 0; j < run_len && done < n_items; j++) begin
        clock_stamp += $urandom_range(1, 10);
        r.time_stamp = ($urandom_range(19) == 0) ? $urandom() : clock_stamp;
        r.queue_occupancy = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                                     : 7'($urandom_range(64));
        case ($urandom_range(9))
          0: r.access_address = $urandom();
          1: r.access_address = base + 32'(step * (j > 0 ? j - 1 : 0));
          default: r.access_address = base + 32'(step * j);
        endcase
        issue(r);
        done++;
      end
    end
  endtask

  // Result checker: compare each accepted prefetch with the oldest prediction.
  always @(posedge clk) begin
    msp_pkg::rsp_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_prefetches.size() == 0) begin
        $error("unexpected prefetch %h", out_rsp.prefetch_address);
        errors++;
      end else begin
        want = pending_prefetches.pop_front();
        if (out_rsp.prefetch_address !== want.prefetch_address) begin
          $error("prefetch_address expected %h actual %h",
                 want.prefetch_address, out_rsp.prefetch_address);
          errors++;
        end
        if (out_rsp.fill_outer !== want.fill_outer) begin
          $error("fill_outer expected %b actual %b", want.fill_outer, out_rsp.fill_outer);
          errors++;
        end
        if (out_rsp.last_request !== want.last_request) begin
          $error("last_request expected %b actual %b",
                 want.last_request, out_rsp.last_request);
          errors++;
        end
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 15);
    end
  end

  // Watchdog on handshake activity.
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Directed rows; typed rows carry their expected prefetches inline.
  typedef struct {
    msp_pkg::req_t r;
    bit            typed;
    int            n;
    msp_pkg::rsp_t e0;
  } row_t;

  row_t rows[$];
  initial begin
    msp_pkg::rsp_t pf_list[$];
    // Address zero right after reset hits entry 0; stamp 0 keeps all stamps equal.
    rows.push_back('{'{32'h0000_0000, 32'd0, 7'd0}, 1, 0, '0});
    // All stamps equal: stride against itself is 0, one prefetch before the page edge.
    rows.push_back('{'{32'h0000_1FC0, 32'd0, 7'd0}, 1, 1, '{32'h0000_1FC0, 1'b0, 1'b1}});
    rows.push_back('{'{32'h0000_0040, 32'd1, 7'd8}, 0, 0, '0});
    rows.push_back('{'{32'h0000_0080, 32'd2, 7'd7}, 0, 0, '0});
    rows.push_back('{'{32'h0000_00C0, 32'd3, 7'd64}, 0, 0, '0});
    rows.push_back('{'{32'h0000_0100, 32'd4, 7'd127}, 0, 0, '0});
    rows.push_back('{'{32'h0000_0140, 32'd5, 7'd9}, 0, 0, '0});
    rows.push_back('{'{32'h0000_0080, 32'd6, 7'd0}, 0, 0, '0});
    rows.push_back('{'{32'hFFFF_FFFF, 32'd7, 7'd127}, 0, 0, '0});
    rows.push_back('{'{32'hFFFF_FFC0, 32'd8, 7'd64}, 0, 0, '0});
    rows.push_back('{'{32'hFFFF_FF80, 32'd9, 7'd0}, 0, 0, '0});
    rows.push_back('{'{32'h0000_0FFF, 32'hFFFF_FFFF, 7'd1}, 0, 0, '0});
    rows.push_back('{'{32'h0000_0FBF, 32'hFFFF_FFFE, 7'd2}, 0, 0, '0});
    rows.push_back('{'{32'h0000_0F7F, 32'd10, 7'd3}, 0, 0, '0});
    rows.push_back('{'{32'h0000_0F3F, 32'd11, 7'd4}, 0, 0, '0});
    rows.push_back('{'{32'h0000_0F3F, 32'd12, 7'd5}, 0, 0, '0});
    rows.push_back('{'{32'hAAAA_5555, 32'h5555_AAAA, 7'd42}, 0, 0, '0});

    for (int i = 0; i < msp_pkg::TABLE_ENTRIES; i++) begin
      sh_new[i] = 0; sh_addr[i] = 0; sh_stamp[i] = 0; sh_stride[i] = 0; sh_conf[i] = 0;
    end
    sh_thresh = msp_pkg::RESET_THRESHOLD;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table.
    foreach (rows[i]) begin
      send_request(rows[i].r, pf_list);
      if (rows[i].typed) begin
        if (rows[i].n > 0) pending_prefetches.push_back(rows[i].e0);
      end else begin
        foreach (pf_list[j]) pending_prefetches.push_back(pf_list[j]);
      end
    end

    // Random phases across threshold settings; the block fills during the hold.
    write_threshold(7'd0);
    hold_req = 1'b1;
    random_phase(45);
    write_threshold(7'd64);
    calm = 1'b1;
    random_phase(45);
    calm = 1'b0;
    write_threshold(7'd127);
    random_phase(45);
    write_threshold(7'($urandom_range(1, 63)));
    random_phase(45);

    in_valid <= 1'b0;
    while (pending_prefetches.size() != 0) @(posedge clk);
    repeat (BUSY_WAIT) @(posedge clk);
    if (errors == 0 && pending_prefetches.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/msp_pkg.sv
hdl/msp_cell.sv
hdl/msp_chain.sv
hdl/miss_stride_prefetcher.sv
verif/tb_top.sv
